// ===== design/sbp_coarse_to_fine_prolongation_macros.svh =====
// ----------------------------------------------------------------------------
// sbp prolongation assertion macros
// shared concurrent assertion forms used by the prolongation design
// ----------------------------------------------------------------------------
`ifndef SBP_COARSE_TO_FINE_PROLONGATION_MACROS_SVH
`define SBP_COARSE_TO_FINE_PROLONGATION_MACROS_SVH

// same-cycle implication
`define SBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbp assertion failed");

// next-cycle implication
`define SBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbp assertion failed");

`endif

// ===== design/sbp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbp_pkg
// types, constants and weight tables of the order 4/2 prolongation
// ----------------------------------------------------------------------------
package sbp_pkg;

    localparam int DEF_MAX_COARSE  = 4096;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int MIN_COARSE      = 11;
    localparam int CFG_BITS        = 13;
    localparam int WIN             = 7;
    localparam int WT_BITS         = 18;
    localparam int FRAC_BITS       = 16;
    localparam int QUEUE_DEPTH     = 4;

    typedef logic signed [WT_BITS-1:0] t_wt;
    typedef t_wt [WIN-1:0] t_wvec;

    typedef enum logic [1:0] {
        K_START,
        K_MID,
        K_END
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] c_small;
    } t_job;

    localparam int BND_W [10][7] = '{
        '{64984, 1104, -552, 0, 0, 0, 0},
        '{26636, 45033, -6132, 0, 0, 0, 0},
        '{-974, 67485, -974, 0, 0, 0, 0},
        '{-4228, 37129, 36732, -4096, 0, 0, 0},
        '{-616, 1232, 64920, 0, 0, 0, 0},
        '{-1333, -663, 33995, 37632, -4096, 0, 0},
        '{-3148, 7662, -5879, 66901, 0, 0, 0},
        '{-861, 2490, -6493, 37632, 36864, -4096, 0},
        '{327, -654, 327, 0, 65536, 0, 0},
        '{1488, -3061, 1658, -4181, 36864, 36864, -4096}
    };

    localparam t_wvec STENCIL = {18'sd0, 18'sd0, 18'sd0,
                                 -18'sd4096, 18'sd36864, 18'sd36864, -18'sd4096};
    localparam t_wt   UNITY   = 18'sd65536;

    // boundary row i seen from the recent window, newest sample is coarse c
    function automatic t_wvec start_row(input logic [3:0] i, input logic [2:0] c);
        t_wvec      w;
        logic [2:0] col;
        w = '0;
        for (int a = 0; a < WIN; a++) begin
            col = c - 3'(a);
            if (3'(a) <= c && i <= 4'd9) begin
                w[a] = t_wt'(BND_W[i][col]);
            end
        end
        return w;
    endfunction

    function automatic t_wvec row_weights(input t_kind kind, input logic [2:0] c,
                                          input logic [3:0] k);
        t_wvec      w;
        logic [4:0] i;
        logic [3:0] j;
        w = '0;
        i = {1'b0, c, 1'b0} + 5'(k) - 5'd3;
        j = 4'd9 - k;
        case (kind)
            K_START: begin
                w = start_row(k, 3'd2);
            end
            K_MID: begin
                if (i <= 5'd9) begin
                    w = start_row(i[3:0], c);
                end else if (k == 4'd0) begin
                    w = STENCIL;
                end else begin
                    w[1] = UNITY;
                end
            end
            K_END: begin
                for (int a = 0; a < WIN; a++) begin
                    if (j <= 4'd9) begin
                        w[a] = t_wt'(BND_W[j][a]);
                    end
                end
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    function automatic logic [3:0] last_k(input t_kind kind);
        logic [3:0] r;
        case (kind)
            K_START: r = 4'd2;
            K_MID:   r = 4'd1;
            K_END:   r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/sbp_front.sv =====
// ----------------------------------------------------------------------------
// sbp_front
// accepts coarse samples, keeps the recent window and frame position,
// and queues one job per sample that produces fine samples
// ----------------------------------------------------------------------------
module sbp_front #(
    parameter int MAX_COARSE  = sbp_pkg::DEF_MAX_COARSE,
    parameter int SAMPLE_BITS = sbp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [SAMPLE_BITS-1:0]             i_sample,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sbp_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  logic                               i_full,
    output logic                               o_push,
    output logic [SAMPLE_BITS*sbp_pkg::WIN-1:0] o_win,
    output sbp_pkg::t_job                      o_job
);
    import sbp_pkg::*;

    localparam int CW = $clog2(MAX_COARSE);
    localparam int NW = $clog2(MAX_COARSE + 1);
    localparam int XW = NW + 1;

    logic [CW-1:0]          r_cnt, n_cnt;
    logic [NW-1:0]          r_len, n_len;
    logic [SAMPLE_BITS-1:0] r_win [WIN];
    logic [SAMPLE_BITS-1:0] n_win [WIN];
    logic                   accept, cfg_wr;
    logic                   is_start, is_mid, is_end;
    logic [XW-1:0]          c, n;
    int unsigned            cfg_val;

    assign o_stall     = i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !i_full;
    assign cfg_wr      = i_cfg_valid;

    assign c        = XW'(r_cnt);
    assign n        = XW'(r_len);
    assign is_start = (c == XW'(2));
    assign is_mid   = (c >= XW'(3)) && (c + XW'(5) <= n);
    assign is_end   = (c + XW'(1) == n);

    always_comb begin
        cfg_val = unsigned'(32'(i_cfg_data));
        if (cfg_val < MIN_COARSE) begin
            n_len = NW'(MIN_COARSE);
        end else if (cfg_val > MAX_COARSE) begin
            n_len = NW'(MAX_COARSE);
        end else begin
            n_len = NW'(cfg_val);
        end
    end

    always_comb begin
        n_win[0] = i_sample;
        for (int a = 1; a < WIN; a++) begin
            n_win[a] = r_win[a-1];
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (cfg_wr) begin
            n_cnt = '0;
        end else if (accept) begin
            n_cnt = is_end ? '0 : r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_len <= NW'(MIN_COARSE);
        end else begin
            r_cnt <= n_cnt;
            if (cfg_wr) begin
                r_len <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < WIN; a++) begin
                r_win[a] <= '0;
            end
        end else if (accept) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        for (int a = 0; a < WIN; a++) begin
            o_win[a*SAMPLE_BITS +: SAMPLE_BITS] = n_win[a];
        end
        o_push          = accept && (is_start || is_mid || is_end);
        o_job.c_small   = (r_cnt > CW'(7)) ? 3'd7 : r_cnt[2:0];
        if (is_start) begin
            o_job.kind = K_START;
        end else if (is_end) begin
            o_job.kind = K_END;
        end else begin
            o_job.kind = K_MID;
        end
    end

endmodule

// ===== design/sbp_queue.sv =====
// ----------------------------------------------------------------------------
// sbp_queue
// small job queue between the front and the back
// ----------------------------------------------------------------------------
`include "sbp_coarse_to_fine_prolongation_macros.svh"

module sbp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sbp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    import sbp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `SBP_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `SBP_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)
    `SBP_ASSERT_NEXT(a_fill_step, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + CW'(1))

endmodule

// ===== design/sbp_back.sv =====
// ----------------------------------------------------------------------------
// sbp_back
// expands queued jobs into fine samples through a weighted sum pipeline
// with round to nearest and saturation
// ----------------------------------------------------------------------------
module sbp_back #(
    parameter int SAMPLE_BITS = sbp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [SAMPLE_BITS*sbp_pkg::WIN-1:0] i_win,
    input  sbp_pkg::t_job                       i_job,
    input  logic                                i_empty,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [SAMPLE_BITS-1:0]              o_fine_sample,
    output logic                                o_run_last,
    output logic                                o_frame_last
);
    import sbp_pkg::*;

    localparam int PW = SAMPLE_BITS + WT_BITS;
    localparam int AW = PW + 3;
    localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
    localparam logic signed [AW-1:0] HALF   = AW'(64'sd1 <<< (FRAC_BITS - 1));

    typedef logic signed [SAMPLE_BITS-1:0] t_smp;

    logic              adv, issue, last;
    logic [3:0]        r_k;
    logic              r_v0, r_v1, r_v2, r_v3, r_ov;
    logic [1:0]        r_fl0, r_fl1, r_fl2, r_fl3;
    t_wvec             r_w0;
    t_smp              r_x0 [WIN];
    logic signed [PW-1:0] r_p1 [WIN];
    logic signed [AW-1:0] r_s2 [4];
    logic signed [AW-1:0] r_s3;
    logic signed [AW-1:0] rnd, q;
    logic [SAMPLE_BITS-1:0] sat;

    assign adv   = !r_ov || !i_stall;
    assign issue = adv && !i_empty;
    assign last  = (r_k == last_k(i_job.kind));
    assign o_pop = issue && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (issue) begin
                r_k <= last ? '0 : r_k + 4'd1;
            end
            if (adv) begin
                r_v0 <= issue;
                r_v1 <= r_v0;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_ov <= r_v3;
            end
        end
    end

    always_comb begin
        rnd = r_s3 + HALF;
        q   = rnd >>> FRAC_BITS;
        if (q > SAT_HI) begin
            sat = SAMPLE_BITS'(SAT_HI);
        end else if (q < SAT_LO) begin
            sat = SAMPLE_BITS'(SAT_LO);
        end else begin
            sat = SAMPLE_BITS'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w0  <= row_weights(i_job.kind, i_job.c_small, r_k);
            r_fl0 <= {last && (i_job.kind == K_END), last};
            for (int a = 0; a < WIN; a++) begin
                r_x0[a] <= t_smp'(i_win[a*SAMPLE_BITS +: SAMPLE_BITS]);
                r_p1[a] <= PW'(r_x0[a]) * PW'(r_w0[a]);
            end
            r_fl1   <= r_fl0;
            r_s2[0] <= AW'(r_p1[0]) + AW'(r_p1[1]);
            r_s2[1] <= AW'(r_p1[2]) + AW'(r_p1[3]);
            r_s2[2] <= AW'(r_p1[4]) + AW'(r_p1[5]);
            r_s2[3] <= AW'(r_p1[6]);
            r_fl2   <= r_fl1;
            r_s3    <= r_s2[0] + r_s2[1] + r_s2[2] + r_s2[3];
            r_fl3   <= r_fl2;
            o_fine_sample <= sat;
            o_run_last    <= r_fl3[0];
            o_frame_last  <= r_fl3[1];
        end
    end

    assign o_valid = r_ov;

endmodule

// ===== design/sbp_coarse_to_fine_prolongation.sv =====
// ----------------------------------------------------------------------------
// sbp_coarse_to_fine_prolongation
// streaming order 4/2 sbp interpolation, n coarse samples to 2n-1 fine samples
// ----------------------------------------------------------------------------
// path: a result passes the job queue, registers x0, p1, s2, s3 and the output
// throughput: one fine sample per cycle from the weighted sum pipeline unless
//   stalled or starved; an interior coarse sample gives 2 and the frame end 10
// a 4-entry job queue lets the input run ahead of the result port
// reset: synchronous active low, empties the queue and pipeline, frame
//   position 0, coarse_len 11
module sbp_coarse_to_fine_prolongation #(
    parameter int MAX_COARSE  = sbp_pkg::DEF_MAX_COARSE,
    parameter int SAMPLE_BITS = sbp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sbp_pkg::CFG_BITS-1:0] i_cfg_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [SAMPLE_BITS-1:0]       o_fine_sample,
    output logic                         o_run_last,
    output logic                         o_frame_last
);
    import sbp_pkg::*;

    localparam int WW = SAMPLE_BITS * WIN;
    localparam int QW = WW + $bits(t_job);

    logic          push, pop, empty, full;
    logic [WW-1:0] f_win, b_win;
    t_job          f_job, b_job;
    logic [QW-1:0] q_out;

    sbp_front #(
        .MAX_COARSE  (MAX_COARSE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_win       (f_win),
        .o_job       (f_job)
    );

    sbp_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_win, f_job}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty),
        .o_full  (full)
    );

    assign b_win = q_out[QW-1 -: WW];
    assign b_job = t_job'(q_out[$bits(t_job)-1:0]);

    sbp_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_win         (b_win),
        .i_job         (b_job),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fine_sample (o_fine_sample),
        .o_run_last    (o_run_last),
        .o_frame_last  (o_frame_last)
    );

endmodule

// ===== sim/sbp_coarse_to_fine_prolongation_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbp_coarse_to_fine_prolongation_tb
// drives coarse frames through the prolongation block under random source and
// sink idling, models each fine sample or uses a known one, and compares each
// result transaction field by field; frame length changes between phases
// ----------------------------------------------------------------------------
module sbp_coarse_to_fine_prolongation_tb;
    import sbp_pkg::*;

    localparam int SB = DEF_SAMPLE_BITS;

    typedef struct {
        logic signed [SB-1:0] fine;
        logic                 run_last;
        logic                 frame_last;
    } t_fine_txn;

    typedef struct {
        logic signed [SB-1:0] sample;
        bit                   known;
        logic signed [SB-1:0] fine;
    } t_stim_row;

    localparam int BW [10][7] = '{
        '{64984, 1104, -552, 0, 0, 0, 0},
        '{26636, 45033, -6132, 0, 0, 0, 0},
        '{-974, 67485, -974, 0, 0, 0, 0},
        '{-4228, 37129, 36732, -4096, 0, 0, 0},
        '{-616, 1232, 64920, 0, 0, 0, 0},
        '{-1333, -663, 33995, 37632, -4096, 0, 0},
        '{-3148, 7662, -5879, 66901, 0, 0, 0},
        '{-861, 2490, -6493, 37632, 36864, -4096, 0},
        '{327, -654, 327, 0, 65536, 0, 0},
        '{1488, -3061, 1658, -4181, 36864, 36864, -4096}
    };
    localparam int TAPS [4] = '{-4096, 36864, 36864, -4096};
    localparam logic signed [SB-1:0] SMAX = 24'sh7fffff;
    localparam logic signed [SB-1:0] SMIN = 24'sh800000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [SB-1:0]        i_sample;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_BITS-1:0]  i_cfg_data;
    logic                 o_valid;
    logic                 i_stall;
    logic [SB-1:0]        o_fine_sample;
    logic                 o_run_last;
    logic                 o_frame_last;

    logic signed [SB-1:0] head_win [WIN];
    logic signed [SB-1:0] tail_win [WIN];
    int                   frame_pos;
    logic [CFG_BITS-1:0]  len_reg;
    t_fine_txn            fine_expected [$];
    int                   errors;
    int                   n_samples;
    int                   n_fines;
    int                   n_cfg;
    int                   sink_wait;
    int                   max_gap;

    sbp_coarse_to_fine_prolongation uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fine_sample (o_fine_sample),
        .o_run_last    (o_run_last),
        .o_frame_last  (o_frame_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    function automatic logic signed [SB-1:0] round_sat(input longint acc);
        longint q;
        q = (acc + 32768) >>> 16;
        if (q > longint'(SMAX)) q = longint'(SMAX);
        if (q < longint'(SMIN)) q = longint'(SMIN);
        return SB'(q);
    endfunction

    function automatic int frame_len();
        int n;
        n = int'(len_reg);
        if (n < MIN_COARSE) n = MIN_COARSE;
        if (n > DEF_MAX_COARSE) n = DEF_MAX_COARSE;
        return n;
    endfunction

    function automatic logic signed [SB-1:0] fine_at(input int i, input int c, input int n);
        longint acc;
        int     last;
        int     age;
        acc  = 0;
        last = 2 * n - 2;
        if (i <= 9) begin
            for (int k = 0; k < WIN; k++) acc += longint'(head_win[k]) * BW[i][k];
            return round_sat(acc);
        end
        if (last - i <= 9) begin
            for (int k = 0; k < WIN; k++) acc += longint'(tail_win[k]) * BW[last - i][k];
            return round_sat(acc);
        end
        if (i % 2 == 0) begin
            age = c - i / 2;
            return (age >= 0 && age < WIN) ? tail_win[age] : '0;
        end
        for (int k = 0; k < 4; k++) begin
            age = c - (i / 2 - 1 + k);
            if (age >= 0 && age < WIN) acc += longint'(tail_win[age]) * TAPS[k];
        end
        return round_sat(acc);
    endfunction

    // shift one coarse sample in and queue the fine samples it completes
    task automatic predict_fine(input logic signed [SB-1:0] s, input bit known,
                                input logic signed [SB-1:0] kval);
        int        n;
        int        c;
        int        lo;
        int        hi;
        t_fine_txn t;
        n  = frame_len();
        c  = frame_pos;
        lo = 1;
        hi = 0;
        for (int k = WIN - 1; k > 0; k--) tail_win[k] = tail_win[k - 1];
        tail_win[0] = s;
        if (c < WIN) head_win[c] = s;
        if (c == 2) begin
            lo = 0; hi = 2;
        end else if (c >= 3 && c + 5 <= n) begin
            lo = 2 * c - 3; hi = 2 * c - 2;
        end else if (c == n - 1) begin
            lo = 2 * n - 11; hi = 2 * n - 2;
        end
        for (int i = lo; i <= hi; i++) begin
            t.fine       = known ? kval : fine_at(i, c, n);
            t.run_last   = (i == hi);
            t.frame_last = (i == 2 * n - 2);
            fine_expected.push_back(t);
        end
        frame_pos = (c + 1 >= n) ? 0 : c + 1;
    endtask

    task automatic send_sample(input logic signed [SB-1:0] s, input bit known,
                               input logic signed [SB-1:0] kval);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
        predict_fine(s, known, kval);
        n_samples++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (fine_expected.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_len(input logic [CFG_BITS-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        len_reg   = v;
        frame_pos = 0;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return SMAX;
            1: return SMIN;
            2: return SB'($urandom_range(0, 255)) - 24'sd128;
            default: return SB'($urandom);
        endcase
    endfunction

    // sink side: stall for a drawn number of cycles before each result
    always @(negedge i_clk) begin
        if (sink_wait > 0) begin
            i_stall   <= 1'b1;
            sink_wait <= sink_wait - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_fine_txn e;
        if (i_rst_n && o_valid && !i_stall) begin
            sink_wait <= (max_gap == 0) ? 0 : $urandom_range(0, 8);
            n_fines++;
            if (fine_expected.size() == 0) begin
                $display("%0t: unexpected result transaction fine %0d", $time,
                         $signed(o_fine_sample));
                errors++;
            end else begin
                e = fine_expected.pop_front();
                if (o_fine_sample !== e.fine) begin
                    $display("%0t: fine_sample expected %0d actual %0d", $time,
                             e.fine, $signed(o_fine_sample));
                    errors++;
                end
                if (o_run_last !== e.run_last) begin
                    $display("%0t: run_last expected %0b actual %0b", $time,
                             e.run_last, o_run_last);
                    errors++;
                end
                if (o_frame_last !== e.frame_last) begin
                    $display("%0t: frame_last expected %0b actual %0b", $time,
                             e.frame_last, o_frame_last);
                    errors++;
                end
            end
        end
    end

    t_stim_row stim [22];

    initial begin
        int n;
        int cnt;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_stall     = 1'b0;
        sink_wait   = 0;
        errors      = 0;
        n_samples   = 0;
        n_fines     = 0;
        n_cfg       = 0;
        max_gap     = 8;
        len_reg     = CFG_BITS'(MIN_COARSE);
        frame_pos   = 0;
        foreach (head_win[k]) begin
            head_win[k] = '0;
            tail_win[k] = '0;
        end
        // zero frame at reset length, then an extreme-value frame
        foreach (stim[r]) begin
            stim[r].sample = '0;
            stim[r].known  = (r < 11);
            stim[r].fine   = '0;
        end
        stim[11].sample = SMAX; stim[12].sample = SMIN; stim[13].sample = SMAX;
        stim[14].sample = SMIN; stim[15].sample = -24'sd1; stim[16].sample = 24'sd1;
        stim[17].sample = SMAX; stim[18].sample = SMAX; stim[19].sample = SMIN;
        stim[20].sample = SMIN; stim[21].sample = SMAX;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim[r]) send_sample(stim[r].sample, stim[r].known, stim[r].fine);

        // length below minimum clamps, all-ones clamps to the maximum
        write_len('0);
        for (int k = 0; k < 11; k++) send_sample(rand_sample(), 0, '0);
        write_len('1);
        for (int k = 0; k < 14; k++) send_sample(rand_sample(), 0, '0);
        // restart mid frame, windows kept
        write_len(CFG_BITS'(12));
        max_gap = 0;
        for (int k = 0; k < 12; k++) send_sample(rand_sample(), 0, '0);
        max_gap = 8;
        write_len(CFG_BITS'(DEF_MAX_COARSE));
        for (int k = 0; k < 9; k++) send_sample(rand_sample(), 0, '0);

        cnt = 0;
        while (cnt < 25) begin
            n = $urandom_range(11, 30);
            write_len(CFG_BITS'(n));
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
            for (int k = 0; k < n; k++) send_sample(rand_sample(), 0, '0);
            cnt += n;
        end
        max_gap = 8;
        drain();

        $display("%0d coarse samples, %0d fine results, %0d length writes, %0d errors",
                 n_samples, n_fines, n_cfg, errors);
        $display("frame lengths from clamped minimum to clamped maximum, mid-frame restarts");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
